### hw/rtl/sslc_pkg.sv
// Package for the sampled serial line codec: phase codes, register indexes,
// reset values, character codes and the configuration struct.
// No dependencies; the interfaces, codec modules and bench take names from here.
package sslc_pkg;

   localparam int CYCLE_COUNT_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLES_PER_BIT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_INTERVAL   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BITS_PER_CHAR     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEWLINE_TO_RETURN = 2'd3;

   localparam logic [7:0]  RESET_SAMPLES_PER_BIT   = 8'd27;
   localparam logic [15:0] RESET_SAMPLE_INTERVAL   = 16'd1000;
   localparam logic [3:0]  RESET_BITS_PER_CHAR     = 4'd7;
   localparam logic        RESET_NEWLINE_TO_RETURN = 1'b1;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_START = 4'b0010,
      PH_DATA  = 4'b0100,
      PH_STOP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] samples_per_bit;
      logic [3:0] bits_per_char;
      logic       newline_to_return;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic sample;
   } ctrl_type;

endpackage

### hw/rtl/sslc_if.sv
// Channel interfaces of the sampled serial line codec: request and response.
// Depends on sslc_pkg for the cycle count width.
interface sslc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [sslc_pkg::CYCLE_COUNT_WIDTH-1:0] cycle_count;
   logic                                   line_out_level;
   logic                                   send_valid;
   logic [7:0]                             send_byte;

   modport source (output valid, cycle_count, line_out_level, send_valid, send_byte,
                   input ready);
   modport sink   (input valid, cycle_count, line_out_level, send_valid, send_byte,
                   output ready);
endinterface

interface sslc_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_in_level;
   logic       char_valid;
   logic [7:0] char_data;
   logic       send_accepted;
   logic       sample_taken;

   modport source (output valid, line_in_level, char_valid, char_data, send_accepted,
                   sample_taken, input ready);
   modport sink   (input valid, line_in_level, char_valid, char_data, send_accepted,
                   sample_taken, output ready);
endinterface

### hw/rtl/sampled_serial_line_codec.sv
// Top level of the sampled serial line codec: input register, sample pacing,
// configuration registers and result register. Uses sslc_pkg, sslc_if,
// sslc_recv and sslc_send.
//
//   channel    role     beat
//   req_chan   sink     cycle count, serial-out level, optional byte to send
//   rsp_chan   source   serial-in level, received char, send/sample flags
//   csr_*      write    register index and data, no read-back
//
// One beat per cycle sustained while rsp is not stalled; a beat passes the input
// register, then the result register, from req to rsp. The 64-bit sample compare
// and the next-sample add set the path. A stalled rsp holds one result while one
// more req beat waits in the input register. Synchronous reset returns the config
// registers, valid flags, pacing and side state to defaults; data regs are kept.
module sampled_serial_line_codec #(
   parameter int CYCLE_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sslc_req_if.sink                             req_chan,
   sslc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [sslc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sslc_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   logic [7:0]  samples_per_bit_ff;
   logic [15:0] sample_interval_ff;
   logic [3:0]  bits_per_char_ff;
   logic        newline_to_return_ff;

   logic                   s1_valid_ff;
   logic [CYCLE_WIDTH-1:0] s1_now_ff;
   logic                   s1_level_ff;
   logic                   s1_offer_ff;
   logic [7:0]             s1_byte_ff;

   logic [CYCLE_WIDTH-1:0] next_at_ff, next_at_in;

   logic       rsp_valid_ff;
   logic       rsp_line_ff;
   logic       rsp_char_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_accepted_ff;
   logic       rsp_sample_ff;

   logic               advance;
   sslc_pkg::cfg_type  cfg;
   sslc_pkg::ctrl_type ctrl;
   logic               recv_done;
   logic [7:0]         recv_char;
   logic               send_accepted;
   logic               drive_level_in;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign ctrl.step   = advance;
   assign ctrl.sample = advance && (s1_now_ff >= next_at_ff);
   assign next_at_in  = next_at_ff + CYCLE_WIDTH'(sample_interval_ff);

   assign cfg.samples_per_bit   = samples_per_bit_ff;
   assign cfg.bits_per_char     = bits_per_char_ff;
   assign cfg.newline_to_return = newline_to_return_ff;

   sslc_recv u_recv (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .level     (s1_level_ff),
      .done      (recv_done),
      .char_data (recv_char)
   );

   sslc_send u_send (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .ctrl           (ctrl),
      .send_valid     (s1_offer_ff),
      .send_byte      (s1_byte_ff),
      .accepted       (send_accepted),
      .drive_level_in (drive_level_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_bit_ff   <= sslc_pkg::RESET_SAMPLES_PER_BIT;
         sample_interval_ff   <= sslc_pkg::RESET_SAMPLE_INTERVAL;
         bits_per_char_ff     <= sslc_pkg::RESET_BITS_PER_CHAR;
         newline_to_return_ff <= sslc_pkg::RESET_NEWLINE_TO_RETURN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sslc_pkg::CSR_SAMPLES_PER_BIT:   samples_per_bit_ff   <= csr_wr_data[7:0];
            sslc_pkg::CSR_SAMPLE_INTERVAL:   sample_interval_ff   <= csr_wr_data;
            sslc_pkg::CSR_BITS_PER_CHAR:     bits_per_char_ff     <= csr_wr_data[3:0];
            sslc_pkg::CSR_NEWLINE_TO_RETURN: newline_to_return_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_now_ff   <= req_chan.cycle_count[CYCLE_WIDTH-1:0];
         s1_level_ff <= req_chan.line_out_level;
         s1_offer_ff <= req_chan.send_valid;
         s1_byte_ff  <= req_chan.send_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_at_ff <= '0;
      end else if (ctrl.sample) begin
         next_at_ff <= next_at_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_line_ff       <= drive_level_in;
         rsp_char_valid_ff <= recv_done;
         rsp_char_ff       <= recv_done ? recv_char : 8'd0;
         rsp_accepted_ff   <= send_accepted;
         rsp_sample_ff     <= ctrl.sample;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_in_level = rsp_line_ff;
   assign rsp_chan.char_valid    = rsp_char_valid_ff;
   assign rsp_chan.char_data     = rsp_char_ff;
   assign rsp_chan.send_accepted = rsp_accepted_ff;
   assign rsp_chan.sample_taken  = rsp_sample_ff;

endmodule

### hw/rtl/sslc_recv.sv
// Receive side: samples the processor serial output and assembles characters.
// Depends on sslc_pkg for phase codes and the configuration struct.
module sslc_recv (
   input  logic             clock,
   input  logic             reset,
   input  sslc_pkg::cfg_type  cfg,
   input  sslc_pkg::ctrl_type ctrl,
   input  logic             level,
   output logic             done,
   output logic [7:0]       char_data
);

   sslc_pkg::phase_type phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in, tick_inc;
   logic [7:0] high_ff, high_in, high_inc;
   logic [3:0] idx_ff, idx_in, idx_inc;
   logic [7:0] char_ff, char_in;
   logic       tick_last;

   assign tick_inc  = tick_ff + 8'd1;
   assign tick_last = tick_inc >= cfg.samples_per_bit;
   assign high_inc  = high_ff + {7'd0, level};
   assign idx_inc   = idx_ff + 4'd1;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      high_in  = high_ff;
      idx_in   = idx_ff;
      char_in  = char_ff;
      done     = 1'b0;
      if (ctrl.sample) begin
         unique case (phase_ff)
            sslc_pkg::PH_IDLE: begin
               if (level) begin
                  tick_in  = 8'd0;
                  phase_in = sslc_pkg::PH_START;
               end
            end
            sslc_pkg::PH_START: begin
               tick_in = tick_inc;
               if (tick_last) begin
                  tick_in  = 8'd0;
                  high_in  = 8'd0;
                  idx_in   = 4'd0;
                  char_in  = 8'd0;
                  phase_in = sslc_pkg::PH_DATA;
               end
            end
            sslc_pkg::PH_DATA: begin
               tick_in = tick_inc;
               high_in = high_inc;
               if (tick_last) begin
                  // inverted polarity: few high samples make a one
                  if (high_inc < {1'b0, cfg.samples_per_bit[7:1]} && !idx_ff[3]) begin
                     char_in[idx_ff[2:0]] = 1'b1;
                  end
                  tick_in = 8'd0;
                  high_in = 8'd0;
                  idx_in  = idx_inc;
                  if (idx_inc >= cfg.bits_per_char) begin
                     phase_in = sslc_pkg::PH_STOP;
                  end
               end
            end
            sslc_pkg::PH_STOP: begin
               tick_in = tick_inc;
               if (tick_last) begin
                  phase_in = sslc_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            end
            default: begin
               phase_in = sslc_pkg::PH_IDLE;
            end
         endcase
      end
   end

   assign char_data = char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sslc_pkg::PH_IDLE;
         tick_ff  <= 8'd0;
         high_ff  <= 8'd0;
         idx_ff   <= 4'd0;
         char_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         high_ff  <= high_in;
         idx_ff   <= idx_in;
         char_ff  <= char_in;
      end
   end

endmodule

### hw/rtl/sslc_send.sv
// Send side: loads offered bytes and drives the processor serial input.
// Depends on sslc_pkg for phase codes, character codes and the config struct.
module sslc_send (
   input  logic             clock,
   input  logic             reset,
   input  sslc_pkg::cfg_type  cfg,
   input  sslc_pkg::ctrl_type ctrl,
   input  logic             send_valid,
   input  logic [7:0]       send_byte,
   output logic             accepted,
   output logic             drive_level_in
);

   sslc_pkg::phase_type phase_ff, phase_in, phase_a;
   logic [7:0] tick_ff, tick_in, tick_a, tick_inc;
   logic [3:0] idx_ff, idx_in, idx_inc;
   logic [7:0] char_ff, char_in, byte_cv;
   logic       drive_level_ff;
   logic       tick_last;

   assign accepted = ctrl.step && send_valid && (phase_ff == sslc_pkg::PH_IDLE);
   assign byte_cv  = (cfg.newline_to_return && send_byte == sslc_pkg::CHAR_LF) ?
                     sslc_pkg::CHAR_CR : send_byte;

   // load the offered byte ahead of the sample tick
   always_comb begin
      phase_a = phase_ff;
      tick_a  = tick_ff;
      char_in = char_ff;
      if (accepted) begin
         phase_a = sslc_pkg::PH_START;
         tick_a  = 8'd0;
         char_in = byte_cv;
      end
   end

   assign tick_inc  = tick_a + 8'd1;
   assign tick_last = tick_inc >= cfg.samples_per_bit;
   assign idx_inc   = idx_ff + 4'd1;

   always_comb begin
      phase_in       = phase_a;
      tick_in        = tick_a;
      idx_in         = idx_ff;
      drive_level_in = drive_level_ff;
      if (ctrl.sample) begin
         unique case (phase_a)
            sslc_pkg::PH_IDLE: begin
               drive_level_in = drive_level_ff;
            end
            sslc_pkg::PH_START: begin
               drive_level_in = 1'b0;
               tick_in        = tick_inc;
               if (tick_last) begin
                  tick_in  = 8'd0;
                  idx_in   = 4'd0;
                  phase_in = sslc_pkg::PH_DATA;
               end
            end
            sslc_pkg::PH_DATA: begin
               drive_level_in = idx_ff[3] ? 1'b0 : char_in[idx_ff[2:0]];
               tick_in        = tick_inc;
               if (tick_last) begin
                  tick_in = 8'd0;
                  idx_in  = idx_inc;
                  if (idx_inc >= cfg.bits_per_char) begin
                     phase_in = sslc_pkg::PH_STOP;
                  end
               end
            end
            sslc_pkg::PH_STOP: begin
               drive_level_in = 1'b1;
               tick_in        = tick_inc;
               if (tick_last) begin
                  phase_in = sslc_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = sslc_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sslc_pkg::PH_IDLE;
         tick_ff        <= 8'd0;
         idx_ff         <= 4'd0;
         char_ff        <= 8'd0;
         drive_level_ff <= 1'b1;
      end else begin
         phase_ff       <= phase_in;
         tick_ff        <= tick_in;
         idx_ff         <= idx_in;
         char_ff        <= char_in;
         drive_level_ff <= drive_level_in;
      end
   end

endmodule

### hw/rtl/sslc_checker.sv
// Port checker for the sampled serial line codec, bound to the top level.
// Depends only on the top level's port names.
module sslc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_char_valid,
   input logic [7:0] rsp_char_data,
   input logic       rsp_sample_taken
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_data))
      else $error("rsp beat dropped or changed while stalled");

   a_char_needs_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_sample_taken)
      else $error("character completed without a sample point");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_data == 8'd0)
      else $error("char data not cleared without a character");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind sampled_serial_line_codec sslc_checker u_sslc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_char_valid   (rsp_chan.char_valid),
   .rsp_char_data    (rsp_chan.char_data),
   .rsp_sample_taken (rsp_chan.sample_taken)
);

### sim/sampled_serial_line_codec_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sampled_serial_line_codec: random and directed line beats,
// with the serial receive and send sides predicted per beat and checked in order.
// Depends on sslc_pkg, sslc_if and the codec RTL.
module sampled_serial_line_codec_tb;

   localparam int CLK_PERIOD     = 12;
   localparam int TIMEOUT_CYCLES = 100000;
   localparam int HOLD_CYCLES    = 200;

   typedef struct packed {
      logic [63:0] cycle_count;
      logic        line_out_level;
      logic        send_valid;
      logic [7:0]  send_byte;
   } line_beat_type;

   typedef struct packed {
      logic       line_in_level;
      logic       char_valid;
      logic [7:0] char_data;
      logic       send_accepted;
      logic       sample_taken;
   } line_result_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_wr_en;
   logic [sslc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [sslc_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data;

   sslc_req_if req_chan ();
   sslc_rsp_if rsp_chan ();

   sampled_serial_line_codec u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   line_beat_type   line_beats[$];
   line_result_type pending_results[$];
   line_beat_type   drive_beat;
   line_beat_type   seen_beat;
   line_result_type want;

   int mismatches;
   int beats_queued;
   int beats_in;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int budget;
   bit hold_request;
   bit hold_started;
   bit req_fired;

   // predicted codec state and configuration
   logic [7:0]          cfg_spb;
   logic [15:0]         cfg_interval;
   logic [3:0]          cfg_bpc;
   logic                cfg_nl;
   logic [63:0]         pace_next;
   sslc_pkg::phase_type rx_phase;
   sslc_pkg::phase_type tx_phase;
   logic [7:0]          rx_tick;
   logic [7:0]          rx_highs;
   logic [3:0]          rx_bit;
   logic [7:0]          rx_char;
   logic [7:0]          tx_tick;
   logic [3:0]          tx_bit;
   logic [7:0]          tx_char;
   logic                tx_level;

   // stimulus-side copy of the sample pacing
   logic [63:0] gen_cycles;
   logic [63:0] gen_next;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic line_result_type predict_result(input line_beat_type b);
      line_result_type r;
      logic [7:0]      byt;
      r = '0;
      if (b.send_valid && tx_phase == sslc_pkg::PH_IDLE) begin
         byt = b.send_byte;
         if (cfg_nl && byt == sslc_pkg::CHAR_LF) begin
            byt = sslc_pkg::CHAR_CR;
         end
         tx_char = byt;
         tx_tick = 8'd0;
         tx_phase = sslc_pkg::PH_START;
         r.send_accepted = 1'b1;
      end
      if (b.cycle_count >= pace_next) begin
         r.sample_taken = 1'b1;
         pace_next = pace_next + 64'(cfg_interval);
         case (rx_phase)
            sslc_pkg::PH_IDLE: begin
               if (b.line_out_level) begin
                  rx_tick = 8'd0;
                  rx_phase = sslc_pkg::PH_START;
               end
            end
            sslc_pkg::PH_START: begin
               rx_tick = rx_tick + 8'd1;
               if (rx_tick >= cfg_spb) begin
                  rx_tick = 8'd0;
                  rx_highs = 8'd0;
                  rx_bit = 4'd0;
                  rx_char = 8'd0;
                  rx_phase = sslc_pkg::PH_DATA;
               end
            end
            sslc_pkg::PH_DATA: begin
               rx_highs = rx_highs + 8'(b.line_out_level);
               rx_tick = rx_tick + 8'd1;
               if (rx_tick >= cfg_spb) begin
                  if (rx_highs < (cfg_spb >> 1) && rx_bit < 4'd8) begin
                     rx_char[rx_bit[2:0]] = 1'b1;
                  end
                  rx_tick = 8'd0;
                  rx_highs = 8'd0;
                  rx_bit = rx_bit + 4'd1;
                  if (rx_bit >= cfg_bpc) begin
                     rx_phase = sslc_pkg::PH_STOP;
                  end
               end
            end
            default: begin
               rx_tick = rx_tick + 8'd1;
               if (rx_tick >= cfg_spb) begin
                  rx_phase = sslc_pkg::PH_IDLE;
                  r.char_valid = 1'b1;
                  r.char_data = rx_char;
               end
            end
         endcase
         case (tx_phase)
            sslc_pkg::PH_START: begin
               tx_level = 1'b0;
               tx_tick = tx_tick + 8'd1;
               if (tx_tick >= cfg_spb) begin
                  tx_tick = 8'd0;
                  tx_bit = 4'd0;
                  tx_phase = sslc_pkg::PH_DATA;
               end
            end
            sslc_pkg::PH_DATA: begin
               tx_level = (tx_bit < 4'd8) ? tx_char[tx_bit[2:0]] : 1'b0;
               tx_tick = tx_tick + 8'd1;
               if (tx_tick >= cfg_spb) begin
                  tx_tick = 8'd0;
                  tx_bit = tx_bit + 4'd1;
                  if (tx_bit >= cfg_bpc) begin
                     tx_phase = sslc_pkg::PH_STOP;
                  end
               end
            end
            sslc_pkg::PH_STOP: begin
               tx_level = 1'b1;
               tx_tick = tx_tick + 8'd1;
               if (tx_tick >= cfg_spb) begin
                  tx_phase = sslc_pkg::PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
      r.line_in_level = tx_level;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   // sample both channels at the rising edge: check results before queuing new predictions
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual char %0h", $time,
                        rsp_chan.char_data);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("line_in_level", 8'(want.line_in_level), 8'(rsp_chan.line_in_level));
               check_field("char_valid", 8'(want.char_valid), 8'(rsp_chan.char_valid));
               check_field("char_data", want.char_data, rsp_chan.char_data);
               check_field("send_accepted", 8'(want.send_accepted), 8'(rsp_chan.send_accepted));
               check_field("sample_taken", 8'(want.sample_taken), 8'(rsp_chan.sample_taken));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_beat.cycle_count = req_chan.cycle_count;
            seen_beat.line_out_level = req_chan.line_out_level;
            seen_beat.send_valid = req_chan.send_valid;
            seen_beat.send_byte = req_chan.send_byte;
            pending_results.push_back(predict_result(seen_beat));
            beats_in++;
         end
      end
   end

   // advance the request side only once the current beat is gone
   always @(negedge clock) begin
      if (!reset && (!req_chan.valid || req_fired)) begin
         if (line_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_beat = line_beats.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.cycle_count <= drive_beat.cycle_count;
            req_chan.line_out_level <= drive_beat.line_out_level;
            req_chan.send_valid <= drive_beat.send_valid;
            req_chan.send_byte <= drive_beat.send_byte;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_beat(input logic [63:0] cc, input logic lvl, input logic offer,
                            input logic [7:0] byt, output bit sampled);
      line_beat_type b;
      b.cycle_count = cc;
      b.line_out_level = lvl;
      b.send_valid = offer;
      b.send_byte = byt;
      sampled = (cc >= gen_next);
      if (sampled) begin
         gen_next = gen_next + 64'(cfg_interval);
      end
      line_beats.push_back(b);
      beats_queued++;
      budget--;
   endtask

   task automatic random_beat(input logic lvl, output bit sampled);
      logic [63:0] cc;
      logic [7:0]  byt;
      if ($urandom_range(39) == 0) begin
         cc = {$urandom, $urandom};
      end else begin
         gen_cycles = gen_cycles + 64'($urandom_range(0, int'(cfg_interval) * 3 / 2));
         cc = gen_cycles;
      end
      byt = ($urandom_range(5) == 0) ? sslc_pkg::CHAR_LF : 8'($urandom);
      push_beat(cc, lvl, ($urandom_range(3) == 0), byt, sampled);
   endtask

   // hold a level for a number of sample ticks, with the odd glitch
   task automatic line_ticks(input logic lvl, input int ticks);
      int n;
      bit s;
      n = 0;
      while (n < ticks && budget > 0) begin
         random_beat(($urandom_range(7) == 0) ? !lvl : lvl, s);
         if (s) begin
            n++;
         end
      end
   endtask

   task automatic send_frame();
      int          spb;
      int          nbits;
      int          i;
      logic [15:0] pattern;
      spb = (cfg_spb < 8'd2) ? 1 : int'(cfg_spb);
      nbits = (cfg_bpc == 4'd0) ? 1 : int'(cfg_bpc);
      pattern = 16'($urandom);
      line_ticks(1'b1, spb + 1);
      for (i = 0; i < nbits; i++) begin
         line_ticks(!pattern[i], spb);
      end
      line_ticks(1'b0, spb + $urandom_range(3));
   endtask

   task automatic drain();
      while (!(beats_in == beats_queued && pending_results.size() == 0)) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sslc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [sslc_pkg::CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      case (idx)
         sslc_pkg::CSR_SAMPLES_PER_BIT: cfg_spb = val[7:0];
         sslc_pkg::CSR_SAMPLE_INTERVAL: cfg_interval = val[15:0];
         sslc_pkg::CSR_BITS_PER_CHAR:   cfg_bpc = val[3:0];
         default:                       cfg_nl = val[0];
      endcase
   endtask

   task automatic apply_config(input logic [7:0] spb, input logic [15:0] interval,
                               input logic [3:0] bpc, input logic nl);
      csr_write(sslc_pkg::CSR_SAMPLES_PER_BIT, 16'(spb));
      csr_write(sslc_pkg::CSR_SAMPLE_INTERVAL, interval);
      csr_write(sslc_pkg::CSR_BITS_PER_CHAR, 16'(bpc));
      csr_write(sslc_pkg::CSR_NEWLINE_TO_RETURN, 16'(nl));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] spb, input logic [15:0] interval,
                            input logic [3:0] bpc, input logic nl, input int idle,
                            input int stall, input int items, input bit hold);
      int n;
      bit s;
      drain();
      apply_config(spb, interval, bpc, nl);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      if (gen_next > gen_cycles) begin
         gen_cycles = gen_next;
      end
      budget = items;
      while (budget > 0) begin
         if ($urandom_range(9) < 7) begin
            send_frame();
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               if (budget > 0) begin
                  random_beat(1'($urandom_range(1)), s);
               end
            end
         end
      end
      if (hold) begin
         hold_request = 1'b1;
      end
   endtask

   initial begin : stimulus
      bit          s;
      int          i;
      logic [15:0] b_levels;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.cycle_count = '0;
      req_chan.line_out_level = 1'b0;
      req_chan.send_valid = 1'b0;
      req_chan.send_byte = '0;
      rsp_chan.ready = 1'b0;
      mismatches = 0;
      beats_queued = 0;
      beats_in = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      hold_request = 1'b0;
      hold_started = 1'b0;
      cfg_spb = sslc_pkg::RESET_SAMPLES_PER_BIT;
      cfg_interval = sslc_pkg::RESET_SAMPLE_INTERVAL;
      cfg_bpc = sslc_pkg::RESET_BITS_PER_CHAR;
      cfg_nl = sslc_pkg::RESET_NEWLINE_TO_RETURN;
      pace_next = '0;
      rx_phase = sslc_pkg::PH_IDLE;
      tx_phase = sslc_pkg::PH_IDLE;
      rx_tick = '0;
      rx_highs = '0;
      rx_bit = '0;
      rx_char = '0;
      tx_tick = '0;
      tx_bit = '0;
      tx_char = '0;
      tx_level = 1'b1;
      gen_cycles = '0;
      gen_next = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: newline conversion, offer while busy, cycle count extremes
      push_beat(64'd0, 1'b0, 1'b1, sslc_pkg::CHAR_LF, s);
      push_beat(64'd0, 1'b1, 1'b1, 8'hFF, s);
      push_beat(64'd999, 1'b1, 1'b0, 8'h00, s);
      push_beat(64'd1000, 1'b1, 1'b0, 8'h00, s);
      push_beat('1, 1'b0, 1'b1, 8'h00, s);
      push_beat(64'h8000_0000_0000_0000, 1'b1, 1'b0, 8'h55, s);
      push_beat(64'h5555_5555_5555_5555, 1'b0, 1'b1, 8'hAA, s);
      push_beat(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 8'h00, s);
      drain();

      // one-tick bits, zero data bits, newline passed through unchanged
      apply_config(8'd1, 16'd1, 4'd0, 1'b0);
      b_levels = 16'b0110_1001_1101_0110;
      for (i = 0; i < 16; i++) begin
         push_beat(gen_next, b_levels[i], (i == 6 || i == 7 || i == 12),
                   (i == 12) ? 8'hFF : sslc_pkg::CHAR_LF, s);
      end

      run_phase(8'd3, 16'd7, 4'd7, 1'b1, 0, 0, 80, 1'b0);
      run_phase(8'd2, 16'd1, 4'd8, 1'b0, 50, 0, 80, 1'b0);
      run_phase(8'd0, 16'd65535, 4'd12, 1'b1, 0, 50, 60, 1'b0);
      run_phase(8'd255, 16'd2, 4'd1, 1'b0, 14, 14, 40, 1'b0);
      run_phase(8'd4, 16'd300, 4'd15, 1'b1, 0, 0, 80, 1'b1);
      run_phase(8'd5, 16'd13, 4'd9, 1'b0, 14, 14, 60, 1'b0);
      drain();

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule
